FILE: rtl/calu_pkg.sv
// Package of the 8-bit handheld processor ALU: operation codes, flag bit
// positions and the word types that travel between the ALU stages.
// Depends on nothing; every other file of the block uses it.
package calu_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;
    localparam int FLAG_W = 4;

    // Flag positions inside the packed Z N H C nibble
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [BYTE_W-1:0] DAA_HI     = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO     = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0]        NIBBLE_MAX = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_DAA   = 5'd10,
        OP_CPL   = 5'd11,
        OP_SCF   = 5'd12,
        OP_CCF   = 5'd13,
        OP_RLCA  = 5'd14,
        OP_RLA   = 5'd15,
        OP_RRCA  = 5'd16,
        OP_RRA   = 5'd17,
        OP_SLA   = 5'd18,
        OP_SRL   = 5'd19,
        OP_SWAP  = 5'd20,
        OP_BIT   = 5'd21,
        OP_SET   = 5'd22,
        OP_RES   = 5'd23,
        OP_ADD16 = 5'd24,
        OP_INC16 = 5'd25,
        OP_DEC16 = 5'd26
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [BIT_W-1:0]  bit_index;
        logic [FLAG_W-1:0] flags_in;
    } req_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
    } rsp_word_t;

endpackage

FILE: rtl/calu_if.sv
// Valid/ready channel interfaces of the ALU: the request channel carries
// one operation word, the response channel one result word.
// Depends on calu_pkg for field widths.
interface calu_req_if;
    logic                          valid;
    logic                          ready;
    logic [calu_pkg::OP_W-1:0]     op;
    logic [calu_pkg::DATA_W-1:0]   operand_a;
    logic [calu_pkg::DATA_W-1:0]   operand_b;
    logic [calu_pkg::BIT_W-1:0]    bit_index;
    logic [calu_pkg::FLAG_W-1:0]   flags_in;

    modport source (output valid, op, operand_a, operand_b, bit_index, flags_in,
                    input ready);
    modport sink   (input valid, op, operand_a, operand_b, bit_index, flags_in,
                    output ready);
endinterface

interface calu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [calu_pkg::DATA_W-1:0]   result;
    logic [calu_pkg::FLAG_W-1:0]   flags_out;

    modport source (output valid, result, flags_out, input ready);
    modport sink   (input valid, result, flags_out, output ready);
endinterface

FILE: rtl/calu_core.sv
// Combinational datapath of the ALU: one operation word in, one result
// word with new flags out. Depends on calu_pkg.
module calu_core
(
    input  calu_pkg::req_word_t req,
    output calu_pkg::rsp_word_t rsp
);

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic        cin;
        logic        c;
        logic [8:0]  sum9;
        logic [4:0]  nib5;
        logic [8:0]  diff9;
        logic [7:0]  r8;
        logic [7:0]  daa1;
        logic        daa_c;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [3:0]  f;
        logic [3:0]  nf;
        logic [15:0] r;

        a     = req.operand_a[7:0];
        b     = req.operand_b[7:0];
        f     = req.flags_in;
        cin   = f[calu_pkg::FLAG_C];
        c     = (req.op == calu_pkg::OP_ADC || req.op == calu_pkg::OP_SBC) ? cin : 1'b0;
        sum9  = {1'b0, a} + {1'b0, b} + {8'd0, c};
        diff9 = {1'b0, a} - {1'b0, b} - {8'd0, c};
        sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
        nib5  = 5'd0;
        r8    = a;
        daa1  = a;
        daa_c = cin;
        nf    = f;
        r     = {8'd0, a};

        case (req.op)
            calu_pkg::OP_ADD, calu_pkg::OP_ADC:
            begin
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
                r    = {8'd0, sum9[7:0]};
                nf   = {sum9[7:0] == 8'd0, 1'b0, nib5[4], sum9[8]};
            end
            calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP:
            begin
                nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
                nf   = {diff9[7:0] == 8'd0, 1'b1, nib5[4], diff9[8]};
                r    = (req.op == calu_pkg::OP_CP) ? {8'd0, a} : {8'd0, diff9[7:0]};
            end
            calu_pkg::OP_AND:
            begin
                r8 = a & b;
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            calu_pkg::OP_OR:
            begin
                r8 = a | b;
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 3'b000};
            end
            calu_pkg::OP_XOR:
            begin
                r8 = a ^ b;
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 3'b000};
            end
            calu_pkg::OP_INC:
            begin
                r8 = a + 8'd1;
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
            end
            calu_pkg::OP_DEC:
            begin
                r8 = a - 8'd1;
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
            end
            calu_pkg::OP_DAA:
            begin
                if (!f[calu_pkg::FLAG_N])
                begin
                    if (cin || a > calu_pkg::DAA_LIMIT)
                    begin
                        daa1  = a + calu_pkg::DAA_HI;
                        daa_c = 1'b1;
                    end
                    r8 = (f[calu_pkg::FLAG_H] || daa1[3:0] > calu_pkg::NIBBLE_MAX)
                         ? daa1 + calu_pkg::DAA_LO : daa1;
                end
                else
                begin
                    daa1 = cin ? a - calu_pkg::DAA_HI : a;
                    r8   = f[calu_pkg::FLAG_H] ? daa1 - calu_pkg::DAA_LO : daa1;
                end
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, f[calu_pkg::FLAG_N], 1'b0, daa_c};
            end
            calu_pkg::OP_CPL:
            begin
                r  = {8'd0, ~a};
                nf = {f[calu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
            end
            calu_pkg::OP_SCF:
                nf = {f[calu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
            calu_pkg::OP_CCF:
                nf = {f[calu_pkg::FLAG_Z], 1'b0, 1'b0, ~cin};
            calu_pkg::OP_RLCA:
            begin
                r  = {8'd0, a[6:0], a[7]};
                nf = {3'b000, a[7]};
            end
            calu_pkg::OP_RLA:
            begin
                r  = {8'd0, a[6:0], cin};
                nf = {3'b000, a[7]};
            end
            calu_pkg::OP_RRCA:
            begin
                r  = {8'd0, a[0], a[7:1]};
                nf = {3'b000, a[0]};
            end
            calu_pkg::OP_RRA:
            begin
                r  = {8'd0, cin, a[7:1]};
                nf = {3'b000, a[0]};
            end
            calu_pkg::OP_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 2'b00, a[7]};
            end
            calu_pkg::OP_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 2'b00, a[0]};
            end
            calu_pkg::OP_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                r  = {8'd0, r8};
                nf = {r8 == 8'd0, 3'b000};
            end
            calu_pkg::OP_BIT:
                nf = {~a[req.bit_index], 1'b0, 1'b1, cin};
            calu_pkg::OP_SET:
                r = {8'd0, a | (8'd1 << req.bit_index)};
            calu_pkg::OP_RES:
                r = {8'd0, a & ~(8'd1 << req.bit_index)};
            calu_pkg::OP_ADD16:
            begin
                r  = sum17[15:0];
                nf = {f[calu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
            end
            calu_pkg::OP_INC16:
                r = req.operand_a + 16'd1;
            calu_pkg::OP_DEC16:
                r = req.operand_a - 16'd1;
            default:
            begin
                // unused codes: pass operand_a and flags through
                r  = req.operand_a;
                nf = f;
            end
        endcase

        rsp.result    = r;
        rsp.flags_out = nf;
    end

endmodule

FILE: rtl/cpu_alu_with_flags_top.sv
// Top level of the 8-bit handheld processor ALU with flags: request input
// register, combinational datapath and result register.
// Depends on calu_pkg, calu_if.sv and calu_core.
//
// One operation word (op, operand_a, operand_b, bit_index, flags_in) goes in
// on the req channel and exactly one word (result, flags_out) comes out on
// the rsp channel, in order. The block keeps no architectural state: each
// word stands alone. It takes one word every clock cycle while the rsp side
// keeps taking results. A word accepted on the req channel lands in the input
// register; its result moves into the result register when that register is
// free, and rsp.valid is high while a result waits there. Both registers
// advance whenever the stage downstream is free. While a finished result
// waits to be taken, the request side accepts one more word into an empty
// input register and then stalls until the result leaves. Unused operation
// codes return operand_a and flags_in unchanged. Eight-bit operations use the
// low operand bytes and zero-extend the result.
module cpu_alu_with_flags_top
(
    input  logic            clk,
    input  logic            rst_n,
    calu_req_if.sink        req,
    calu_rsp_if.source      rsp
);

    // input register stage
    logic                  s1_valid_reg;
    calu_pkg::req_word_t   s1_data_reg;
    // result register stage
    logic                  s2_valid_reg;
    calu_pkg::rsp_word_t   s2_data_reg;

    logic                  s1_ready;
    logic                  s2_ready;
    calu_pkg::req_word_t   req_word;
    calu_pkg::rsp_word_t   core_rsp;

    // a stage takes a new word when empty or when its word leaves this cycle
    assign s2_ready = !s2_valid_reg || rsp.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    assign req_word.op        = req.op;
    assign req_word.operand_a = req.operand_a;
    assign req_word.operand_b = req.operand_b;
    assign req_word.bit_index = req.bit_index;
    assign req_word.flags_in  = req.flags_in;

    // capture the request word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_data_reg <= req_word;
        end
    end

    calu_core u_core
    (
        .req (s1_data_reg),
        .rsp (core_rsp)
    );

    // hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= core_rsp;
        end
    end

    assign rsp.valid     = s2_valid_reg;
    assign rsp.result    = s2_data_reg.result;
    assign rsp.flags_out = s2_data_reg.flags_out;

    // an accepted request shows up in the input register
    a_req_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted request word not captured");

    // a word moving forward lands in the result register
    a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("word lost between input and result register");

    // the result register holds what the datapath computed
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> (s2_data_reg == $past(core_rsp)))
        else $error("result register differs from datapath output");

    // back-pressure on the request side only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && s2_valid_reg))
        else $error("request stalled while a stage is free");

endmodule
